// File: hw/rtl/bmhpq_pkg.sv
// Shared constants, types and helpers for the binary max-heap priority queue.
`timescale 1ns / 1ps

package bmhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Heap positions are one-based; the store is addressed from zero.
	function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [COUNT_W-1:0] p);
		logic [COUNT_W-1:0] tmp;
		tmp = p - COUNT_W'(1);
		return tmp[ADDR_W-1:0];
	endfunction

endpackage

// File: hw/rtl/bmhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bmhpq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/bmhpq_cmp.sv
// Shared signed key comparator used by every sift step.
`timescale 1ns / 1ps

module bmhpq_cmp (
	input  logic [bmhpq_pkg::KEY_W-1:0] a,
	input  logic [bmhpq_pkg::KEY_W-1:0] b,
	output logic                        lt
);
	import bmhpq_pkg::*;

	// True when a is strictly smaller than b as two's complement keys.
	assign lt = $signed(a) < $signed(b);

endmodule

// File: hw/rtl/bmhpq_ctrl.sv
// Sequencer that walks the heap one level at a time for insert and remove.
`timescale 1ns / 1ps

module bmhpq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          action,
	input  logic [bmhpq_pkg::KEY_W-1:0]   value,
	output logic                          busy,
	output logic                          done,
	output logic [bmhpq_pkg::KEY_W-1:0]   removed_value,
	output logic [1:0]                    status,
	output logic [bmhpq_pkg::COUNT_W-1:0] fill_count,
	output bmhpq_pkg::mem_req_t           mem_req,
	input  logic [bmhpq_pkg::KEY_W-1:0]   mem_rdata,
	output logic [bmhpq_pkg::KEY_W-1:0]   cmp_a,
	output logic [bmhpq_pkg::KEY_W-1:0]   cmp_b,
	input  logic                          cmp_lt
);
	import bmhpq_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_UP_RD   = 10'b0000000010,
		S_UP_CMP  = 10'b0000000100,
		S_RM_ROOT = 10'b0000001000,
		S_RM_LAST = 10'b0000010000,
		S_DN_RDL  = 10'b0000100000,
		S_DN_CL   = 10'b0001000000,
		S_DN_CR   = 10'b0010000000,
		S_DN_MV   = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [COUNT_W-1:0] pos_q, pos_d;
	logic [COUNT_W-1:0] best_pos_q, best_pos_d;
	logic [KEY_W-1:0]   key_q, key_d;
	logic [KEY_W-1:0]   best_val_q, best_val_d;
	logic [KEY_W-1:0]   removed_q, removed_d;
	logic [1:0]         status_q, status_d;
	logic [COUNT_W:0]   left_w, right_w, cnt_ext;

	assign left_w  = {pos_q, 1'b0};
	assign right_w = left_w + (COUNT_W + 1)'(1);
	assign cnt_ext = {1'b0, count_q};

	// The comparator is shared: parent against key going up, best against child going down.
	always_comb begin
		if (state_q == S_UP_CMP) begin
			cmp_a = mem_rdata;
			cmp_b = key_q;
		end else begin
			cmp_a = best_val_q;
			cmp_b = mem_rdata;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		pos_d      = pos_q;
		best_pos_d = best_pos_q;
		key_d      = key_q;
		best_val_d = best_val_q;
		removed_d  = removed_q;
		status_d   = status_q;
		mem_req    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					removed_d = '0;
					status_d  = ST_OK;
					if (action == ACT_INSERT) begin
						if (count_q >= COUNT_W'(CAPACITY)) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else begin
							count_d = count_q + COUNT_W'(1);
							pos_d   = count_q + COUNT_W'(1);
							key_d   = value;
							state_d = S_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = pos_to_addr(COUNT_W'(1));
							state_d       = S_RM_ROOT;
						end
					end
				end
			end
			S_UP_RD: begin
				if (pos_q > COUNT_W'(1)) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = pos_to_addr(pos_q >> 1);
					state_d       = S_UP_CMP;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_to_addr(pos_q);
					mem_req.wdata = key_q;
					state_d       = S_DONE;
				end
			end
			S_UP_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_to_addr(pos_q);
				if (cmp_lt) begin
					mem_req.wdata = mem_rdata;
					pos_d         = pos_q >> 1;
					state_d       = S_UP_RD;
				end else begin
					mem_req.wdata = key_q;
					state_d       = S_DONE;
				end
			end
			S_RM_ROOT: begin
				removed_d     = mem_rdata;
				mem_req.re    = 1'b1;
				mem_req.raddr = pos_to_addr(count_q);
				state_d       = S_RM_LAST;
			end
			S_RM_LAST: begin
				key_d   = mem_rdata;
				count_d = count_q - COUNT_W'(1);
				pos_d   = COUNT_W'(1);
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				best_val_d = key_q;
				best_pos_d = pos_q;
				if (left_w <= cnt_ext) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = pos_to_addr(left_w[COUNT_W-1:0]);
					state_d       = S_DN_CL;
				end else begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_to_addr(pos_q);
					mem_req.wdata = key_q;
					state_d       = S_DONE;
				end
			end
			S_DN_CL: begin
				if (cmp_lt) begin
					best_val_d = mem_rdata;
					best_pos_d = left_w[COUNT_W-1:0];
				end
				if (right_w <= cnt_ext) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = pos_to_addr(right_w[COUNT_W-1:0]);
					state_d       = S_DN_CR;
				end else begin
					state_d = S_DN_MV;
				end
			end
			S_DN_CR: begin
				if (cmp_lt) begin
					best_val_d = mem_rdata;
					best_pos_d = right_w[COUNT_W-1:0];
				end
				state_d = S_DN_MV;
			end
			S_DN_MV: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_to_addr(pos_q);
				if (best_pos_q != pos_q) begin
					mem_req.wdata = best_val_q;
					pos_d         = best_pos_q;
					state_d       = S_DN_RDL;
				end else begin
					mem_req.wdata = key_q;
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		best_pos_q <= best_pos_d;
		key_q      <= key_d;
		best_val_q <= best_val_d;
		removed_q  <= removed_d;
		status_q   <= status_d;
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign removed_value = removed_q;
	assign status        = status_q;
	assign fill_count    = count_q;

endmodule

// File: hw/rtl/binary_max_heap_priority_queue_top.sv
// Top level of the binary max-heap priority queue.
`timescale 1ns / 1ps

// Binary max-heap priority queue of 32-bit signed keys, 64 entries deep.
// A command word is taken at a rising edge where start is high and busy is
// low: action 0 inserts value, action 1 removes the largest key held.
// Each command yields exactly one result word, shown for a single cycle
// while done is high: removed_value (the maximum on a good remove, else
// zero), status (ok, remove on empty, insert on full) and fill_count.
// The receiver cannot hold results off; it must take the word in that cycle.
// The heap lives in a single RAM with one write and one registered read
// port. A sequencer walks the heap one level at a time and a single shared
// comparator settles every step. Busy stays high from the accepting edge
// until the end of the result cycle, and the next word can be taken in the
// cycle after. An insert reads the parent at each level climbed and moves it
// down while it is smaller than the key, then writes the key where it stops;
// a remove fetches the root and then the last entry, and at each level it
// reads the children that exist, moves the larger one up if it beats the
// moved key, and at last writes the moved key in place. Full-insert and
// empty-remove commands go straight to the result word and leave the
// heap untouched. Reset clears the fill count and the sequencer; the RAM is
// not cleared, since only positions that have been written are ever read.
module binary_max_heap_priority_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic signed [bmhpq_pkg::KEY_W-1:0] value,
	output logic                          done,
	output logic signed [bmhpq_pkg::KEY_W-1:0] removed_value,
	output logic [1:0]                    status,
	output logic [bmhpq_pkg::COUNT_W-1:0] fill_count
);
	import bmhpq_pkg::*;

	mem_req_t         mem_req;
	logic [KEY_W-1:0] mem_rdata;
	logic [KEY_W-1:0] cmp_a, cmp_b;
	logic             cmp_lt;
	logic [KEY_W-1:0] removed_u;

	// The sequencer owns the count, the sift position and the result word.
	bmhpq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.value        ($unsigned(value)),
		.busy         (busy),
		.done         (done),
		.removed_value(removed_u),
		.status       (status),
		.fill_count   (fill_count),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.cmp_a        (cmp_a),
		.cmp_b        (cmp_b),
		.cmp_lt       (cmp_lt)
	);

	// One comparator serves both the upward and the downward sift.
	bmhpq_cmp u_cmp (
		.a (cmp_a),
		.b (cmp_b),
		.lt(cmp_lt)
	);

	// Heap store, position p held at address p - 1.
	bmhpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(KEY_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(mem_rdata)
	);

	assign removed_value = $signed(removed_u);

`ifndef SYNTHESIS
	// A result word only appears while a command is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result word outside a command");

	// An accepted command always makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("command accepted but block not busy");

	// The fill count never exceeds the heap capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= COUNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	// Failed commands never report a removed key.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (removed_value == '0))
		else $error("removed key on a failed command");

	// A failed command leaves the fill count as it was.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> $stable(fill_count))
		else $error("fill count changed on a failed command");
`endif

endmodule

// File: tb/heap_shadow_pkg.sv
// Shadow max-heap that predicts and checks the result words of the priority queue.
`timescale 1ns / 1ps

package heap_shadow_pkg;

	import bmhpq_pkg::*;

	typedef struct packed {
		logic signed [KEY_W-1:0] removed;
		logic [1:0]              status;
		logic [COUNT_W-1:0]      fill;
	} heap_word_t;

	class heap_shadow;

		logic signed [KEY_W-1:0] keys [0:CAPACITY];
		int                      held;
		heap_word_t              owed_words [$];
		int                      failures;

		function new();
			held     = 0;
			failures = 0;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		local function void swap_keys(int a, int b);
			logic signed [KEY_W-1:0] tmp;
			tmp     = keys[a];
			keys[a] = keys[b];
			keys[b] = tmp;
		endfunction

		// Applies one accepted command to the shadow heap and queues its word.
		function void take_command(logic act, logic signed [KEY_W-1:0] key);
			heap_word_t w;
			int         pos;
			int         best;
			int         kid;
			w.removed = '0;
			w.status  = ST_OK;
			if (act == ACT_INSERT) begin
				if (held >= CAPACITY) begin
					w.status = ST_FULL;
				end else begin
					held++;
					keys[held] = key;
					pos = held;
					while (pos > 1) begin
						if (keys[pos / 2] < keys[pos]) begin
							swap_keys(pos / 2, pos);
							pos = pos / 2;
						end else begin
							break;
						end
					end
				end
			end else begin
				if (held == 0) begin
					w.status = ST_EMPTY;
				end else begin
					w.removed = keys[1];
					keys[1]   = keys[held];
					held--;
					pos = 1;
					while (1) begin
						best = pos;
						kid  = 2 * pos;
						if (kid <= held && keys[best] < keys[kid])
							best = kid;
						if (kid + 1 <= held && keys[best] < keys[kid + 1])
							best = kid + 1;
						if (best == pos)
							break;
						swap_keys(best, pos);
						pos = best;
					end
				end
			end
			w.fill = COUNT_W'(held);
			owed_words.push_back(w);
		endfunction

		// Compares one result word with the oldest one owed.
		function void check_word(logic signed [KEY_W-1:0] removed, logic [1:0] status,
				logic [COUNT_W-1:0] fill);
			heap_word_t w;
			if (owed_words.size() == 0) begin
				$error("result word with nothing owed: removed_value %0d status %0d fill_count %0d",
					removed, status, fill);
				failures++;
				return;
			end
			w = owed_words.pop_front();
			if (removed !== w.removed) begin
				$error("removed_value: expected %0d, got %0d", w.removed, removed);
				failures++;
			end
			if (status !== w.status) begin
				$error("status: expected %0d, got %0d", w.status, status);
				failures++;
			end
			if (fill !== w.fill) begin
				$error("fill_count: expected %0d, got %0d", w.fill, fill);
				failures++;
			end
		endfunction

	endclass

endpackage

// File: tb/tb_top.sv
// Self-checking testbench for the binary max-heap priority queue top level.
`timescale 1ns / 1ps

// The bench drives insert and remove command words into the queue and keeps
// a shadow heap that predicts every result word. A monitor samples the ports
// at each rising edge: a command word is noted when start is high and busy is
// low, and a result word is checked whenever done is high. The stimulus opens
// with a short directed run (remove from empty, the key extremes, equal keys),
// then three random phases in which the sender idles seldom, often and never.
// Each phase first fills the heap past its capacity and drains it past empty,
// then runs bursts that lean towards inserts, towards removes or neither.
module tb_top;

	import bmhpq_pkg::*;
	import heap_shadow_pkg::*;

	localparam int END_SETTLE = 40;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic                     action = ACT_INSERT;
	logic signed [KEY_W-1:0]  value  = '0;
	logic                     busy;
	logic                     done;
	logic signed [KEY_W-1:0]  removed_value;
	logic [1:0]               status;
	logic [COUNT_W-1:0]       fill_count;

	heap_shadow shadow;
	int         idle_pct = 0;

	binary_max_heap_priority_queue_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.value         (value),
		.done          (done),
		.removed_value (removed_value),
		.status        (status),
		.fill_count    (fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The monitor reads the values that stood before the edge, so it does not
	// matter in which order the processes woken by the edge run. A result word
	// is checked before the command of the same edge is noted; a word can never
	// belong to a command accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.check_word(removed_value, status, fill_count);
			if (start && !busy)
				shadow.take_command(action, value);
		end
	end

	// Keys lean towards the extremes and a narrow band around zero, so that
	// equal keys turn up often; the rest are uniform over the full range.
	function automatic logic signed [KEY_W-1:0] random_key();
		case ($urandom_range(9)) inside
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2, 3:    return KEY_W'($urandom_range(8)) - KEY_W'(4);
			default: return $urandom();
		endcase
	endfunction

	// Presents one command word and holds it until the queue takes it. Start
	// stays high when the next word follows straight on; otherwise the sender
	// idles for a while and puts noise on the ignored fields.
	task automatic send_command(input logic act, input logic signed [KEY_W-1:0] key);
		start  <= 1'b1;
		action <= act;
		value  <= key;
		do @(posedge clk); while (busy);
		while ($urandom_range(99) < idle_pct) begin
			start  <= 1'b0;
			action <= 1'($urandom_range(1));
			value  <= $urandom();
			@(posedge clk);
		end
	endtask

	// Holds the sender off until every owed result word has come back. The
	// first edge makes sure that the last accepted command has been noted.
	task automatic drain_queue();
		start <= 1'b0;
		do @(posedge clk); while (shadow.pending() != 0);
	endtask

	task automatic run_phase(input int pct, input int n_items);
		int sent;
		int burst_len;
		int insert_bias;
		idle_pct = pct;
		// Climb past capacity so that inserts into a full heap are refused,
		// then fall past empty so that removes from an empty heap are refused.
		for (int k = 0; k < CAPACITY + 3; k++)
			send_command(ACT_INSERT, random_key());
		for (int k = 0; k < CAPACITY + 3; k++)
			send_command(ACT_REMOVE, random_key());
		sent = 2 * (CAPACITY + 3);
		while (sent < n_items) begin
			case ($urandom_range(3))
				0:       insert_bias = 85;
				1:       insert_bias = 15;
				default: insert_bias = 50;
			endcase
			burst_len = $urandom_range(120, 20);
			if (burst_len > n_items - sent)
				burst_len = n_items - sent;
			repeat (burst_len) begin
				send_command(($urandom_range(99) < insert_bias) ? ACT_INSERT : ACT_REMOVE,
					random_key());
				sent++;
			end
		end
		drain_queue();
	endtask

	initial begin
		shadow = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run: a remove from the empty heap, both key extremes, zero,
		// minus one, a repeated maximum and three equal keys, so that the
		// sift-down meets equal children. Everything is then taken out again
		// in order, and one more remove finds the heap empty.
		idle_pct = 0;
		send_command(ACT_REMOVE, 32'sh7fff_ffff);
		send_command(ACT_INSERT, 32'sd0);
		send_command(ACT_INSERT, 32'sh7fff_ffff);
		send_command(ACT_INSERT, 32'sh8000_0000);
		send_command(ACT_INSERT, -32'sd1);
		send_command(ACT_INSERT, 32'sd1);
		send_command(ACT_INSERT, 32'sh7fff_ffff);
		send_command(ACT_INSERT, 32'sd5);
		send_command(ACT_INSERT, 32'sd5);
		send_command(ACT_INSERT, 32'sd5);
		repeat (10)
			send_command(ACT_REMOVE, $urandom());
		drain_queue();

		// Random phases: the idle chance is seven percent, then sixty-nine,
		// then zero. Each phase ends by waiting for every owed result word.
		run_phase(7, 500);
		run_phase(69, 500);
		run_phase(0, 500);

		// Give a stray word time to show up before the verdict.
		repeat (END_SETTLE) @(posedge clk);
		if (shadow.failures == 0 && shadow.pending() == 0)
			$display("PASS binary_max_heap_priority_queue_top");
		else
			$display("FAIL binary_max_heap_priority_queue_top");
		$finish;
	end

	// Watchdog: a correct run takes well under a tenth of this.
	initial begin
		#5_000_000;
		$display("FAIL binary_max_heap_priority_queue_top");
		$finish;
	end

endmodule
